// ===== hdl/pti_pkg.sv =====
// pti_pkg: shared types, constants and the threshold table for the
// poisson threshold interpolator; no dependencies
package pti_pkg;

    localparam int LAMBDA_FRAC_BITS_DEF = 30;
    localparam int TABLE_ROWS           = 62;
    localparam int TABLE_COLUMNS        = 5;
    localparam int LAMBDA_W             = 61;
    localparam int EPS_W                = 32;
    localparam int THR_W                = 34;
    localparam int ERR_W                = 2;
    localparam int ENTRY_W              = 18;
    localparam int ROW_W                = ENTRY_W * TABLE_COLUMNS;
    localparam int ROW_AW               = $clog2(TABLE_ROWS);
    localparam int POS_W                = $clog2(LAMBDA_W);
    localparam int DIFF_W               = 26;
    localparam int RECIP_W              = 41;
    localparam int RECIP_LO_W           = 21;
    localparam int RECIP_HI_W           = RECIP_W - RECIP_LO_W;

    typedef logic [ERR_W-1:0] err_t;
    localparam err_t ERR_OK     = 2'd0;
    localparam err_t ERR_LAMBDA = 2'd1;
    localparam err_t ERR_EPS    = 2'd2;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd42950;

    localparam logic [EPS_W-1:0] EPS_PT0 = 32'd4295;
    localparam logic [EPS_W-1:0] EPS_PT1 = 32'd42950;
    localparam logic [EPS_W-1:0] EPS_PT2 = 32'd429497;
    localparam logic [EPS_W-1:0] EPS_PT3 = 32'd4294967;
    localparam logic [EPS_W-1:0] EPS_PT4 = 32'd42949673;

    localparam logic [63:0] GAP0 = 64'(EPS_PT1 - EPS_PT0);
    localparam logic [63:0] GAP1 = 64'(EPS_PT2 - EPS_PT1);
    localparam logic [63:0] GAP2 = 64'(EPS_PT3 - EPS_PT2);
    localparam logic [63:0] GAP3 = 64'(EPS_PT4 - EPS_PT3);

    localparam logic [RECIP_W-1:0] RECIP0 = RECIP_W'(((64'd1 << 56) + GAP0 - 64'd1) / GAP0);
    localparam logic [RECIP_W-1:0] RECIP1 = RECIP_W'(((64'd1 << 56) + GAP1 - 64'd1) / GAP1);
    localparam logic [RECIP_W-1:0] RECIP2 = RECIP_W'(((64'd1 << 56) + GAP2 - 64'd1) / GAP2);
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((64'd1 << 56) + GAP3 - 64'd1) / GAP3);

    typedef struct packed {
        logic [ROW_AW-1:0] addr;
        logic              we;
    } fill_t;

    function automatic logic [ROW_W-1:0] rom_pack(input int c0, input int c1, input int c2,
                                                  input int c3, input int c4);
        rom_pack = {ENTRY_W'(c4), ENTRY_W'(c3), ENTRY_W'(c2), ENTRY_W'(c1), ENTRY_W'(c0)};
    endfunction

    function automatic logic [ROW_W-1:0] rom_row(input logic [ROW_AW-1:0] r);
        logic [ROW_W-1:0] v;
        case (r)
            6'd13, 6'd14, 6'd15:        v = rom_pack(2, 1, 1, 1, 1);
            6'd16, 6'd17, 6'd18:        v = rom_pack(2, 2, 1, 1, 1);
            6'd19, 6'd20, 6'd21, 6'd22: v = rom_pack(2, 2, 2, 1, 1);
            6'd23, 6'd24: v = rom_pack(3, 2, 2, 2, 1);
            6'd25: v = rom_pack(3, 3, 2, 2, 1);
            6'd26: v = rom_pack(3, 3, 3, 2, 2);
            6'd27: v = rom_pack(4, 3, 3, 2, 2);
            6'd28: v = rom_pack(4, 4, 3, 3, 2);
            6'd29: v = rom_pack(5, 4, 5, 3, 2);
            6'd30: v = rom_pack(6, 5, 5, 4, 3);
            6'd31: v = rom_pack(7, 6, 6, 5, 3);
            6'd32: v = rom_pack(9, 8, 7, 6, 4);
            6'd33: v = rom_pack(12, 10, 9, 7, 6);
            6'd34: v = rom_pack(15, 14, 12, 10, 8);
            6'd35: v = rom_pack(21, 19, 16, 14, 10);
            6'd36: v = rom_pack(28, 26, 22, 19, 14);
            6'd37: v = rom_pack(39, 35, 31, 26, 20);
            6'd38: v = rom_pack(55, 49, 43, 36, 27);
            6'd39: v = rom_pack(77, 69, 61, 50, 38);
            6'd40: v = rom_pack(109, 98, 85, 71, 54);
            6'd41: v = rom_pack(153, 138, 120, 100, 75);
            6'd42: v = rom_pack(216, 194, 169, 141, 106);
            6'd43: v = rom_pack(305, 274, 239, 199, 150);
            6'd44: v = rom_pack(431, 387, 338, 281, 212);
            6'd45: v = rom_pack(609, 547, 477, 397, 299);
            6'd46: v = rom_pack(861, 773, 674, 560, 422);
            6'd47: v = rom_pack(1217, 1092, 953, 792, 596);
            6'd48: v = rom_pack(1721, 1545, 1347, 1119, 843);
            6'd49: v = rom_pack(2434, 2184, 1905, 1583, 1192);
            6'd50: v = rom_pack(3442, 3089, 2693, 2238, 1685);
            6'd51: v = rom_pack(4868, 4368, 3809, 3165, 2383);
            6'd52: v = rom_pack(6884, 6177, 5386, 4476, 3369);
            6'd53: v = rom_pack(9736, 8735, 7617, 6329, 4765);
            6'd54: v = rom_pack(13768, 12353, 10772, 8951, 6738);
            6'd55: v = rom_pack(19471, 17469, 15234, 12658, 9529);
            6'd56: v = rom_pack(27535, 24705, 21543, 17901, 13476);
            6'd57: v = rom_pack(38941, 34938, 30467, 25316, 19058);
            6'd58: v = rom_pack(55070, 49410, 43086, 35802, 26952);
            6'd59: v = rom_pack(77881, 69876, 60933, 50631, 38115);
            6'd60: v = rom_pack(110140, 98820, 86172, 71603, 53903);
            6'd61: v = rom_pack(155761, 139752, 121865, 101261, 76230);
            default: v = rom_pack(1, 1, 1, 1, 1);
        endcase
        rom_row = v;
    endfunction

endpackage

// ===== hdl/pti_ram.sv =====
// pti_ram: generic synchronous ram, one write port, two registered read ports
// depends on nothing
module pti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

// ===== hdl/poisson_threshold_interpolator.sv =====
// Poisson detection threshold by bilinear interpolation over a 62 x 5 table
// held in pti_ram (loaded from pti_pkg after reset); uses pti_pkg, pti_ram
//
// One word in, one word out, at a sustained rate of one word per cycle while m_ready
// is high and the table is loaded. The pipeline stages are epsilon setup, lambda
// bracket and table read, lambda blend, and epsilon blend into the output register.
// After reset the table ram is loaded one row a cycle, so s_ready stays low until
// the last row is written; epsilon writes on cfg_wr_en are taken at any time.
module poisson_threshold_interpolator
    import pti_pkg::*;
#(
    parameter int LAMBDA_FRAC_BITS = pti_pkg::LAMBDA_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pti_pkg::EPS_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pti_pkg::LAMBDA_W-1:0]  s_lambda,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pti_pkg::THR_W-1:0]     m_threshold,
    output logic [pti_pkg::ERR_W-1:0]     m_error_code
);
    localparam logic [63:0] LAM_MAX = 64'd1 << (30 + LAMBDA_FRAC_BITS);
    localparam logic [63:0] LAM_MIN = 64'd1 << (LAMBDA_FRAC_BITS - 30);
    localparam logic [6:0]  LAST_ROW = 7'(TABLE_ROWS - 1);

    // config and table load
    logic [EPS_W-1:0]  eps_reg;
    logic [ROW_AW-1:0] fill_cnt_reg, fill_cnt_next;
    logic              fill_done_reg, fill_done_next;
    fill_t             fill;

    // stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1
    logic [LAMBDA_W-1:0]              s1_lam_reg;
    err_t                             s1_err_reg;
    logic [1:0]                       s1_col_reg;
    logic [DIFF_W+RECIP_LO_W-1:0]     s1_pplo_reg;
    logic [DIFF_W+RECIP_HI_W-1:0]     s1_pphi_reg;
    logic [1:0]                       col_next;
    logic [EPS_W-1:0]                 base_pt;
    logic [RECIP_W-1:0]               recip;
    logic [DIFF_W-1:0]                diff;
    err_t                             err1_next;

    // stage 2
    logic [POS_W-1:0]   lead;
    logic [6:0]         row_sum;
    logic [ROW_AW-1:0]  row_lo, row_hi;
    logic               top_row;
    logic [LAMBDA_W-1:0] rest;
    logic [LAMBDA_W+31:0] rest_ext;
    logic [31:0]        frac_next;
    logic [66:0]        wprod;
    logic [24:0]        w_next;
    err_t               err2_next;
    logic               small_next;
    logic [31:0]        s2_frac_reg;
    logic [24:0]        s2_w_reg;
    err_t               s2_err_reg;
    logic               s2_small_reg;
    logic [1:0]         s2_col_reg;
    logic [ROW_W-1:0]   rd_lo, rd_hi;

    // stage 3
    logic [2:0]         col_a;
    logic [ENTRY_W-1:0] y1, y2, y3, y4;
    logic [32:0]        inv_frac;
    logic [51:0]        lerp_b, lerp_a;
    logic [THR_W-1:0]   s3_vb_reg, s3_va_reg;
    logic [24:0]        s3_w_reg;
    err_t               s3_err_reg;
    logic               s3_small_reg;

    // stage 4
    logic [24:0]        inv_w;
    logic [60:0]        blend;
    logic [THR_W-1:0]   thr_next;
    logic [THR_W-1:0]   out_thr_reg;
    err_t               out_err_reg;

    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1 && fill_done_reg;

    always_comb begin
        fill_cnt_next  = fill_cnt_reg;
        fill_done_next = fill_done_reg;
        if (!fill_done_reg) begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
            if (fill_cnt_reg == ROW_AW'(TABLE_ROWS - 1)) begin
                fill_done_next = 1'b1;
            end
        end
        fill.we   = !fill_done_reg;
        fill.addr = fill_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg       <= EPS_RESET;
            fill_cnt_reg  <= '0;
            fill_done_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                eps_reg <= cfg_wr_data;
            end
            fill_cnt_reg  <= fill_cnt_next;
            fill_done_reg <= fill_done_next;
        end
    end

    // epsilon column pair and weight partial products
    always_comb begin
        if (eps_reg <= EPS_PT1) begin
            col_next = 2'd0;
        end else if (eps_reg <= EPS_PT2) begin
            col_next = 2'd1;
        end else if (eps_reg <= EPS_PT3) begin
            col_next = 2'd2;
        end else begin
            col_next = 2'd3;
        end
        case (col_next)
            2'd0:    begin base_pt = EPS_PT0; recip = RECIP0; end
            2'd1:    begin base_pt = EPS_PT1; recip = RECIP1; end
            2'd2:    begin base_pt = EPS_PT2; recip = RECIP2; end
            default: begin base_pt = EPS_PT3; recip = RECIP3; end
        endcase
        diff      = DIFF_W'(eps_reg - base_pt);
        err1_next = (eps_reg < EPS_PT0 || eps_reg > EPS_PT4) ? ERR_EPS : ERR_OK;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_lam_reg  <= s_lambda;
            s1_err_reg  <= err1_next;
            s1_col_reg  <= col_next;
            s1_pplo_reg <= diff * recip[RECIP_LO_W-1:0];
            s1_pphi_reg <= diff * recip[RECIP_W-1:RECIP_LO_W];
        end
    end

    // lambda bracket, fraction, epsilon weight
    always_comb begin
        lead = '0;
        for (int i = 0; i < LAMBDA_W; i++) begin
            if (s1_lam_reg[i]) begin
                lead = POS_W'(i);
            end
        end
        row_sum = 7'(lead) + 7'(31) - 7'(LAMBDA_FRAC_BITS);
        top_row = row_sum >= LAST_ROW;
        row_lo  = top_row ? ROW_AW'(TABLE_ROWS - 1) : row_sum[ROW_AW-1:0];
        row_hi  = top_row ? row_lo : row_lo + 1'b1;
        rest    = s1_lam_reg & ~(LAMBDA_W'(1) << lead);
        rest_ext = {rest, 32'd0} >> lead;
        frac_next = top_row ? 32'd0 : rest_ext[31:0];
        wprod  = 67'(s1_pplo_reg) + (67'(s1_pphi_reg) << RECIP_LO_W);
        w_next = (wprod[66:32] > 35'(1 << 24)) ? 25'(1 << 24) : wprod[56:32];
        if (s1_err_reg != ERR_OK) begin
            err2_next = s1_err_reg;
        end else if ({3'd0, s1_lam_reg} > LAM_MAX) begin
            err2_next = ERR_LAMBDA;
        end else begin
            err2_next = ERR_OK;
        end
        small_next = {3'd0, s1_lam_reg} <= LAM_MIN;
    end

    pti_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .aclk    (aclk),
        .we      (fill.we),
        .waddr   (fill.addr),
        .wdata   (rom_row(fill.addr)),
        .re      (en2),
        .raddr_a (row_lo),
        .raddr_b (row_hi),
        .rdata_a (rd_lo),
        .rdata_b (rd_hi)
    );

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_frac_reg  <= frac_next;
            s2_w_reg     <= w_next;
            s2_err_reg   <= err2_next;
            s2_small_reg <= small_next;
            s2_col_reg   <= s1_col_reg;
        end
    end

    // lambda interpolation in both columns
    always_comb begin
        col_a    = 3'(s2_col_reg) + 3'd1;
        y1       = rd_lo[s2_col_reg * ENTRY_W +: ENTRY_W];
        y2       = rd_hi[s2_col_reg * ENTRY_W +: ENTRY_W];
        y3       = rd_lo[col_a * ENTRY_W +: ENTRY_W];
        y4       = rd_hi[col_a * ENTRY_W +: ENTRY_W];
        inv_frac = 33'(1) << 32;
        inv_frac = inv_frac - 33'(s2_frac_reg);
        lerp_b   = 52'(y1 * inv_frac) + 52'(y2 * s2_frac_reg) + 52'(1 << 15);
        lerp_a   = 52'(y3 * inv_frac) + 52'(y4 * s2_frac_reg) + 52'(1 << 15);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_vb_reg    <= lerp_b[16 +: THR_W];
            s3_va_reg    <= lerp_a[16 +: THR_W];
            s3_w_reg     <= s2_w_reg;
            s3_err_reg   <= s2_err_reg;
            s3_small_reg <= s2_small_reg;
        end
    end

    // epsilon blend and result select
    always_comb begin
        inv_w = 25'(1 << 24) - s3_w_reg;
        blend = 61'(s3_vb_reg * inv_w) + 61'(s3_va_reg * s3_w_reg) + 61'(1 << 23);
        if (s3_err_reg != ERR_OK) begin
            thr_next = '0;
        end else if (s3_small_reg) begin
            thr_next = THR_W'(1 << 16);
        end else begin
            thr_next = blend[24 +: THR_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            out_thr_reg <= thr_next;
            out_err_reg <= s3_err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid && s_ready;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    assign m_valid      = v4_reg;
    assign m_threshold  = out_thr_reg;
    assign m_error_code = out_err_reg;

    // no word taken before the table is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_done_reg |-> !s_ready)
        else $error("input taken during table load");

    // error results carry a zero threshold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_OK |-> m_threshold == '0)
        else $error("nonzero threshold with error code");

    // load ends right after the last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fill_done_reg) |-> $past(fill_cnt_reg) == ROW_AW'(TABLE_ROWS - 1))
        else $error("table load ended early");

    // a stalled stage three keeps its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !en3 |=> v3_reg)
        else $error("stage three word lost");
endmodule
